@@ rtl/core/matrix3x3_inverse_unit_defines.svh @@
// Assertion macros used by the checker file of the 3x3 inverse block.
// Depends on nothing; include by bare file name.
`ifndef MATRIX3X3_INVERSE_UNIT_DEFINES_SVH
`define MATRIX3X3_INVERSE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define MI3_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while rst is high.
`define MI3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/core/mi3_pkg.sv @@
// Package for the 3x3 inverse block: widths, pipeline depth, cofactor table, types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package mi3_pkg;
   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 24;
   localparam int LANES      = 9;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int COF_W      = PROD_W + 1;
   localparam int PART_W     = DATA_W + 33;
   localparam int TERM_W     = PART_W + 32;
   localparam int DET_W      = TERM_W + 2;
   localparam int DIV_W      = DET_W - 1;
   localparam int REM_W      = DIV_W + 1;
   localparam int NUM_W      = COF_W + 2 * FRAC_BITS;
   localparam int DIV_STEPS  = DATA_W;
   localparam int PIPE_DEPTH = 7 + DIV_STEPS;
   localparam int THR_W      = 31;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);
   localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

   // operand indexes (row-major) of each adjugate element: a*b - c*d
   localparam int COF_IDX [LANES][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic signed [COF_W-1:0]  cof_type;

   typedef struct packed {
      logic [DIV_W-1:0] mag;
      logic             neg;
      logic             singular;
   } det_info_type;
endpackage

@@ rtl/core/matrix3x3_inverse_unit.sv @@
// 3x3 matrix inverse by the adjugate method, signed Q8.24 in and out.
// Depends on mi3_pkg, mi3_cof_lane, mi3_det_merge, mi3_div_lane.
//
// Input channel req_*: one transaction carries nine matrix elements, row-major.
// Output channel rsp_*: nine inverse elements plus singular and saturated flags.
// csr_wr_en/csr_wr_data write the 31-bit singular threshold; write it only while
// the block is empty.
// Throughput: one matrix per cycle while the output is not stalled. Nine
// cofactor lanes (two 32x32 multiplies each) feed a shared determinant stage,
// then nine divider lanes produce one quotient bit per stage over 32 stages;
// the divider length sets the latency.
// Stall: when a result sits in the output register and rsp_ready is low, the
// whole pipeline holds and req_ready drops; otherwise req_ready stays high
// even while the output register is occupied.
// Reset: clears all valid bits and loads the threshold with 17 (about 1e-6).
`timescale 1ns / 1ps
module matrix3x3_inverse_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mi3_pkg::elem_type         req_in_r0c0,
   input  mi3_pkg::elem_type         req_in_r0c1,
   input  mi3_pkg::elem_type         req_in_r0c2,
   input  mi3_pkg::elem_type         req_in_r1c0,
   input  mi3_pkg::elem_type         req_in_r1c1,
   input  mi3_pkg::elem_type         req_in_r1c2,
   input  mi3_pkg::elem_type         req_in_r2c0,
   input  mi3_pkg::elem_type         req_in_r2c1,
   input  mi3_pkg::elem_type         req_in_r2c2,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mi3_pkg::elem_type         rsp_out_r0c0,
   output mi3_pkg::elem_type         rsp_out_r0c1,
   output mi3_pkg::elem_type         rsp_out_r0c2,
   output mi3_pkg::elem_type         rsp_out_r1c0,
   output mi3_pkg::elem_type         rsp_out_r1c1,
   output mi3_pkg::elem_type         rsp_out_r1c2,
   output mi3_pkg::elem_type         rsp_out_r2c0,
   output mi3_pkg::elem_type         rsp_out_r2c1,
   output mi3_pkg::elem_type         rsp_out_r2c2,
   output logic                      rsp_singular,
   output logic                      rsp_saturated,
   input  logic                      csr_wr_en,
   input  logic [mi3_pkg::THR_W-1:0] csr_wr_data
);
   import mi3_pkg::*;

   logic                  en;
   elem_type              mat [LANES];
   cof_type               cof [LANES];
   logic [COF_W-1:0]      cof_mag [LANES];
   logic                  cof_neg [LANES];
   elem_type              lane_res [LANES];
   logic [LANES-1:0]      lane_clip;
   logic [LANES-1:0]      lane_sing;
   det_info_type          det_info;
   logic [THR_W-1:0]      thr_ff;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                  rsp_valid_ff;
   elem_type              out_ff [LANES];
   logic                  sing_ff, sat_ff;

   assign mat = '{req_in_r0c0, req_in_r0c1, req_in_r0c2,
                  req_in_r1c0, req_in_r1c1, req_in_r1c2,
                  req_in_r2c0, req_in_r2c1, req_in_r2c2};

   // hold everything while a result waits on a stalled receiver
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      mi3_cof_lane u_cof (
         .clock   (clock),
         .en      (en),
         .op_a    (mat[COF_IDX[i][0]]),
         .op_b    (mat[COF_IDX[i][1]]),
         .op_c    (mat[COF_IDX[i][2]]),
         .op_d    (mat[COF_IDX[i][3]]),
         .cof     (cof[i]),
         .cof_mag (cof_mag[i]),
         .cof_neg (cof_neg[i])
      );
      mi3_div_lane u_div (
         .clock    (clock),
         .en       (en),
         .cof_mag  (cof_mag[i]),
         .cof_neg  (cof_neg[i]),
         .det_info (det_info),
         .result   (lane_res[i]),
         .clipped  (lane_clip[i]),
         .singular (lane_sing[i])
      );
   end

   mi3_det_merge u_det (
      .clock     (clock),
      .en        (en),
      .m0        (req_in_r0c0),
      .m1        (req_in_r0c1),
      .m2        (req_in_r0c2),
      .c0        (cof[0]),
      .c3        (cof[3]),
      .c6        (cof[6]),
      .threshold (thr_ff),
      .det_info  (det_info)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (en) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
         end
      end
   end

   // every lane carries the same singular flag
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff  <= lane_res;
         sing_ff <= &lane_sing;
         sat_ff  <= |lane_clip;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_r0c0  = out_ff[0];
   assign rsp_out_r0c1  = out_ff[1];
   assign rsp_out_r0c2  = out_ff[2];
   assign rsp_out_r1c0  = out_ff[3];
   assign rsp_out_r1c1  = out_ff[4];
   assign rsp_out_r1c2  = out_ff[5];
   assign rsp_out_r2c0  = out_ff[6];
   assign rsp_out_r2c1  = out_ff[7];
   assign rsp_out_r2c2  = out_ff[8];
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;
endmodule

@@ rtl/core/mi3_cof_lane.sv @@
// One cofactor lane: two products, their difference, and its magnitude and sign.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_cof_lane (
   input  logic              clock,
   input  logic              en,
   input  mi3_pkg::elem_type op_a,
   input  mi3_pkg::elem_type op_b,
   input  mi3_pkg::elem_type op_c,
   input  mi3_pkg::elem_type op_d,
   output mi3_pkg::cof_type  cof,
   output logic [mi3_pkg::COF_W-1:0] cof_mag,
   output logic              cof_neg
);
   import mi3_pkg::*;

   logic signed [PROD_W-1:0] pa_ff, pb_ff;
   cof_type                  cof_ff;
   cof_type                  dly_ff [3];
   logic [COF_W-1:0]         mag_ff;
   logic                     neg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff     <= op_a * op_b;
         pb_ff     <= op_c * op_d;
         cof_ff    <= COF_W'(pa_ff) - COF_W'(pb_ff);
         dly_ff[0] <= cof_ff;
         dly_ff[1] <= dly_ff[0];
         dly_ff[2] <= dly_ff[1];
         neg_ff    <= dly_ff[2][COF_W-1];
         mag_ff    <= dly_ff[2][COF_W-1] ? COF_W'(-dly_ff[2]) : COF_W'(dly_ff[2]);
      end
   end

   assign cof     = cof_ff;
   assign cof_mag = mag_ff;
   assign cof_neg = neg_ff;
endmodule

@@ rtl/core/mi3_det_merge.sv @@
// Determinant from the first row and three lane cofactors, plus the singular test.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_det_merge (
   input  logic                  clock,
   input  logic                  en,
   input  mi3_pkg::elem_type     m0,
   input  mi3_pkg::elem_type     m1,
   input  mi3_pkg::elem_type     m2,
   input  mi3_pkg::cof_type      c0,
   input  mi3_pkg::cof_type      c3,
   input  mi3_pkg::cof_type      c6,
   input  logic [mi3_pkg::THR_W-1:0] threshold,
   output mi3_pkg::det_info_type det_info
);
   import mi3_pkg::*;

   elem_type                 row_ff [2][3];
   logic signed [PART_W-1:0] lo_ff [3];
   logic signed [PART_W-1:0] hi_ff [3];
   logic signed [TERM_W-1:0] term_ff [3];
   logic signed [DET_W-1:0]  det_ff;
   det_info_type             info_ff;
   cof_type                  cof_sel [3];
   logic [DIV_W-1:0]         mag;
   logic [DIV_W-1:0]         thr_scaled;

   assign cof_sel[0] = c0;
   assign cof_sel[1] = c3;
   assign cof_sel[2] = c6;
   assign mag        = det_ff[DET_W-1] ? DIV_W'(-det_ff) : DIV_W'(det_ff);
   assign thr_scaled = DIV_W'({threshold, {(2*FRAC_BITS){1'b0}}});

   // split each 32 x 65 product into two 32 x 33 halves
   always_ff @(posedge clock) begin
      if (en) begin
         row_ff[0] <= '{m0, m1, m2};
         row_ff[1] <= row_ff[0];
         for (int i = 0; i < 3; i++) begin
            lo_ff[i]   <= row_ff[1][i] * $signed({1'b0, cof_sel[i][31:0]});
            hi_ff[i]   <= row_ff[1][i] * $signed(cof_sel[i][COF_W-1:32]);
            term_ff[i] <= TERM_W'(lo_ff[i]) + $signed({hi_ff[i], 32'b0});
         end
         det_ff <= DET_W'(term_ff[0]) + DET_W'(term_ff[1]) + DET_W'(term_ff[2]);
         info_ff.mag      <= mag;
         info_ff.neg      <= det_ff[DET_W-1];
         info_ff.singular <= (det_ff == '0) || (mag < thr_scaled);
      end
   end

   assign det_info = info_ff;
endmodule

@@ rtl/core/mi3_div_lane.sv @@
// Pipelined restoring divider lane: one quotient bit per stage, then truncate/saturate.
// Depends on mi3_pkg.
`timescale 1ns / 1ps
module mi3_div_lane (
   input  logic                  clock,
   input  logic                  en,
   input  logic [mi3_pkg::COF_W-1:0] cof_mag,
   input  logic                  cof_neg,
   input  mi3_pkg::det_info_type det_info,
   output mi3_pkg::elem_type     result,
   output logic                  clipped,
   output logic                  singular
);
   import mi3_pkg::*;

   logic [NUM_W-1:0]  num;
   logic [REM_W-1:0]  rem_in;
   logic [REM_W-1:0]  rem_ff  [DIV_STEPS+1];
   logic [DATA_W-1:0] low_ff  [DIV_STEPS+1];
   logic [DATA_W-1:0] quo_ff  [DIV_STEPS+1];
   logic [DIV_W-1:0]  dvs_ff  [DIV_STEPS+1];
   logic              neg_ff  [DIV_STEPS+1];
   logic              ovf_ff  [DIV_STEPS+1];
   logic              sng_ff  [DIV_STEPS+1];
   logic [REM_W-1:0]  shift_in [DIV_STEPS];
   logic              fits    [DIV_STEPS];
   logic [DATA_W-1:0] q_last;

   assign num    = {cof_mag, {(2*FRAC_BITS){1'b0}}};
   assign rem_in = REM_W'(num[NUM_W-1:DATA_W]);

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         shift_in[k] = {rem_ff[k][REM_W-2:0], low_ff[k][DATA_W-1]};
         fits[k]     = shift_in[k] >= {1'b0, dvs_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in;
         low_ff[0] <= num[DATA_W-1:0];
         quo_ff[0] <= '0;
         dvs_ff[0] <= det_info.mag;
         neg_ff[0] <= cof_neg ^ det_info.neg;
         ovf_ff[0] <= rem_in >= {1'b0, det_info.mag};
         sng_ff[0] <= det_info.singular;
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k+1] <= fits[k] ? shift_in[k] - {1'b0, dvs_ff[k]} : shift_in[k];
            low_ff[k+1] <= {low_ff[k][DATA_W-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][DATA_W-2:0], fits[k]};
            dvs_ff[k+1] <= dvs_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            sng_ff[k+1] <= sng_ff[k];
         end
      end
   end

   assign q_last   = quo_ff[DIV_STEPS];
   assign singular = sng_ff[DIV_STEPS];

   always_comb begin
      result  = '0;
      clipped = 1'b0;
      if (sng_ff[DIV_STEPS]) begin
         result  = '0;
      end else if (neg_ff[DIV_STEPS]) begin
         if (ovf_ff[DIV_STEPS] || q_last > NEG_LIMIT) begin
            result  = NEG_LIMIT;
            clipped = 1'b1;
         end else begin
            result  = -q_last;
         end
      end else if (ovf_ff[DIV_STEPS] || q_last[DATA_W-1]) begin
         result  = POS_LIMIT;
         clipped = 1'b1;
      end else begin
         result  = q_last;
      end
   end
endmodule

@@ rtl/core/mi3_checker.sv @@
// Port-level checker for the 3x3 inverse block, bound to the top level.
// Depends on mi3_pkg and matrix3x3_inverse_unit_defines.svh.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_unit_defines.svh"
module mi3_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input mi3_pkg::elem_type         rsp_out_r0c0,
   input mi3_pkg::elem_type         rsp_out_r0c1,
   input mi3_pkg::elem_type         rsp_out_r0c2,
   input mi3_pkg::elem_type         rsp_out_r1c0,
   input mi3_pkg::elem_type         rsp_out_r1c1,
   input mi3_pkg::elem_type         rsp_out_r1c2,
   input mi3_pkg::elem_type         rsp_out_r2c0,
   input mi3_pkg::elem_type         rsp_out_r2c1,
   input mi3_pkg::elem_type         rsp_out_r2c2,
   input logic                      rsp_singular,
   input logic                      rsp_saturated
);
   import mi3_pkg::*;

   logic all_zero, any_limit;

   assign all_zero = (rsp_out_r0c0 == '0) && (rsp_out_r0c1 == '0) && (rsp_out_r0c2 == '0) &&
                     (rsp_out_r1c0 == '0) && (rsp_out_r1c1 == '0) && (rsp_out_r1c2 == '0) &&
                     (rsp_out_r2c0 == '0) && (rsp_out_r2c1 == '0) && (rsp_out_r2c2 == '0);

   assign any_limit =
      (rsp_out_r0c0 == POS_LIMIT) || (rsp_out_r0c0 == NEG_LIMIT) ||
      (rsp_out_r0c1 == POS_LIMIT) || (rsp_out_r0c1 == NEG_LIMIT) ||
      (rsp_out_r0c2 == POS_LIMIT) || (rsp_out_r0c2 == NEG_LIMIT) ||
      (rsp_out_r1c0 == POS_LIMIT) || (rsp_out_r1c0 == NEG_LIMIT) ||
      (rsp_out_r1c1 == POS_LIMIT) || (rsp_out_r1c1 == NEG_LIMIT) ||
      (rsp_out_r1c2 == POS_LIMIT) || (rsp_out_r1c2 == NEG_LIMIT) ||
      (rsp_out_r2c0 == POS_LIMIT) || (rsp_out_r2c0 == NEG_LIMIT) ||
      (rsp_out_r2c1 == POS_LIMIT) || (rsp_out_r2c1 == NEG_LIMIT) ||
      (rsp_out_r2c2 == POS_LIMIT) || (rsp_out_r2c2 == NEG_LIMIT);

   `MI3_ASSERT_IMPLY(a_singular_zero, clock, reset, rsp_valid && rsp_singular,
                     all_zero && !rsp_saturated)
   `MI3_ASSERT_IMPLY(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, any_limit)
   `MI3_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `MI3_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_out_r1c1) && $stable(rsp_singular))
   `MI3_ASSERT_IMPLY(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)
endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (.*);
